>>> rtl/core/ltrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltrs_pkg
// Command codes, register indexes, interpolation constants and vertex field
// helpers for the line and triangle raster store.
// ----------------------------------------------------------------------------
package ltrs_pkg;

   // Command codes carried by req_cmd.
   typedef enum logic [2:0] {
      CMD_FILL_COLOR = 3'd0,
      CMD_FILL_DEPTH = 3'd1,
      CMD_LINE       = 3'd2,
      CMD_TRIANGLE   = 3'd3,
      CMD_READ       = 3'd4
   } cmd_type;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1,
      CSR_WEIGHT_THR   = 2'd2,
      CSR_UNUSED       = 2'd3
   } csr_index_type;

   // Interpolation target: one of the three colour channels or the depth.
   typedef enum logic [1:0] {
      SEL_CHAN0 = 2'd0,
      SEL_CHAN1 = 2'd1,
      SEL_CHAN2 = 2'd2,
      SEL_DEPTH = 2'd3
   } sel_type;

   // Quotient bits produced by the divider for depth and for a colour channel.
   localparam int Z_BITS = 24;
   localparam int C_BITS = 8;

   // Vertex word fields: signed x, signed y, depth fraction.
   function automatic logic signed [11:0] vert_x(input logic [47:0] v);
      vert_x = $signed(v[47:36]);
   endfunction

   function automatic logic signed [11:0] vert_y(input logic [47:0] v);
      vert_y = $signed(v[35:24]);
   endfunction

   function automatic logic [23:0] vert_z(input logic [47:0] v);
      vert_z = v[23:0];
   endfunction

endpackage

>>> rtl/core/line_and_triangle_raster_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_and_triangle_raster_store
// Frame-store engine with a colour store and a depth store in two synchronous
// memories, driven by a sequencer that fills, draws lines, draws depth-tested
// Gouraud triangles and reads back pixels.
// ----------------------------------------------------------------------------
// One command is taken when start is high and busy is low; busy then stays
// high until the single result word is shown on the rsp_ ports for one cycle
// with rsp_valid high. The receiver cannot stall, so the word must be taken in
// that cycle. The pace is set by the memory write port, the multipliers and
// the bit-serial divider: a fill writes each pixel in turn, a line walks its
// pixels and stops early outside the frame, a read passes address, memory and
// output states. After setup a triangle tests each pixel of its bounding box;
// a pixel passing the weight test is divided for depth, then for each colour
// channel if it passes the depth test (24 divider steps for depth, 8 per channel).
module line_and_triangle_raster_store
   import ltrs_pkg::*;
#(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_cmd,
   input  logic [47:0] req_vert_a,
   input  logic [47:0] req_vert_b,
   input  logic [47:0] req_vert_c,
   input  logic [23:0] req_color_a,
   input  logic [23:0] req_color_b,
   input  logic [23:0] req_color_c,
   input  logic [7:0]  req_line_level,
   input  logic [23:0] req_depth_fill,
   input  logic [7:0]  req_read_x,
   input  logic [7:0]  req_read_y,
   output logic        rsp_valid,
   output logic [23:0] rsp_read_color,
   output logic [23:0] rsp_read_depth,
   output logic        rsp_done_res,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int NW     = ADDR_W + 1;
   // Largest width and height allowed: MAX_WIDTH and MAX_HEIGHT, capped at 511 for the 9-bit registers.
   localparam int WCAP   = (MAX_WIDTH > 511) ? 511 : MAX_WIDTH;
   localparam int HCAP   = (MAX_HEIGHT > 511) ? 511 : MAX_HEIGHT;
   localparam int WRST   = (WCAP < 256) ? WCAP : 256;
   localparam int HRST   = (HCAP < 256) ? HCAP : 256;

   typedef enum logic [25:0] {
      ST_IDLE     = 26'b1 << 0,
      ST_FILL_C   = 26'b1 << 1,
      ST_FILL_D   = 26'b1 << 2,
      ST_LINE_SET = 26'b1 << 3,
      ST_LINE_RUN = 26'b1 << 4,
      ST_TRI_BOX  = 26'b1 << 5,
      ST_TRI_D1   = 26'b1 << 6,
      ST_TRI_D2   = 26'b1 << 7,
      ST_TRI_THR  = 26'b1 << 8,
      ST_TRI_IDX  = 26'b1 << 9,
      ST_PIX_M1   = 26'b1 << 10,
      ST_PIX_M2   = 26'b1 << 11,
      ST_PIX_M3   = 26'b1 << 12,
      ST_PIX_M4   = 26'b1 << 13,
      ST_PIX_W    = 26'b1 << 14,
      ST_PIX_THR  = 26'b1 << 15,
      ST_PIX_MAC  = 26'b1 << 16,
      ST_PIX_DIVI = 26'b1 << 17,
      ST_PIX_DIV  = 26'b1 << 18,
      ST_PIX_ZCMP = 26'b1 << 19,
      ST_PIX_CWR  = 26'b1 << 20,
      ST_PIX_ADV  = 26'b1 << 21,
      ST_RD_ADDR  = 26'b1 << 22,
      ST_RD_MEM   = 26'b1 << 23,
      ST_RD_OUT   = 26'b1 << 24,
      ST_DONE     = 26'b1 << 25
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers and the derived pixel count.
   logic [8:0]    width_ff, height_ff;
   logic [15:0]   thr_ff;
   logic [NW-1:0] n_ff;
   logic [17:0]   wh_prod;

   // Captured command word.
   logic [2:0]  cmd_ff;
   logic [47:0] va_ff, vb_ff, vc_ff;
   logic [23:0] ca_ff, cb_ff, cc_ff;
   logic [7:0]  level_ff;
   logic [23:0] dfill_ff;
   logic [7:0]  rx_ff, ry_ff;

   // Result registers.
   logic [23:0] out_color_ff, out_depth_ff;
   logic        inb_ff;

   // Fill counter.
   logic [ADDR_W-1:0] fcnt_ff;

   // Line walker.
   logic signed [23:0] lidx_ff, linc0_ff, linc1_ff;
   logic [12:0]        lng_ff, sht_ff, lcnt_ff;
   logic [13:0]        acc_ff;

   // Triangle setup and pixel walk.
   logic [8:0]          tx0_ff, ty0_ff;
   logic [8:0]          xmin_ff, xmax_ff, ymin_ff, ymax_ff;
   logic [8:0]          x_ff, y_ff;
   logic signed [9:0]   e1x_ff, e1y_ff, e2x_ff, e2y_ff;
   logic signed [19:0]  prod_ff;
   logic                neg_ff;
   logic [19:0]         dd_ff;
   logic [35:0]         thrdd_ff;
   logic [ADDR_W-1:0]   tidx_ff, trow_ff;
   logic signed [20:0]  wb_ff, wc_ff;
   logic signed [21:0]  wa_ff, wbp_ff, wcp_ff;
   logic [44:0]         num_ff;
   logic [1:0]          term_ff;
   sel_type             sel_ff;
   logic [19:0]         rem_ff;
   logic [23:0]         low_ff, q_ff;
   logic [4:0]          dcnt_ff;
   logic [23:0]         col_ff;

   // Memories and their ports.
   logic [23:0]       color_mem [DEPTH];
   logic [23:0]       depth_mem [DEPTH];
   logic [23:0]       col_rd_ff, dep_rd_ff;
   logic              col_we, dep_we, rd_en;
   logic [ADDR_W-1:0] col_wa, dep_wa, rd_addr;
   logic [23:0]       col_wd, dep_wd;

   logic accept;

   assign accept    = start && !busy;
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   assign rsp_valid      = (state_ff == ST_DONE);
   assign rsp_done_res   = (state_ff == ST_DONE);
   assign rsp_read_color = out_color_ff;
   assign rsp_read_depth = out_depth_ff;

   // Configuration writes with saturation to the legal range.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 9'(WRST);
         height_ff <= 9'(HRST);
         thr_ff    <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_FRAME_WIDTH: begin
               if (csr_wdata[8:0] == 9'd0) width_ff <= 9'd1;
               else if (csr_wdata[8:0] > 9'(WCAP)) width_ff <= 9'(WCAP);
               else width_ff <= csr_wdata[8:0];
            end
            CSR_FRAME_HEIGHT: begin
               if (csr_wdata[8:0] == 9'd0) height_ff <= 9'd1;
               else if (csr_wdata[8:0] > 9'(HCAP)) height_ff <= 9'(HCAP);
               else height_ff <= csr_wdata[8:0];
            end
            CSR_WEIGHT_THR: begin
               thr_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // Pixel count of the active frame.
   assign wh_prod = width_ff * height_ff;

   always_ff @(posedge clock) begin
      n_ff <= NW'(wh_prod);
   end

   // ------------------------------------------------------------------
   // Combinational helpers for the setup and step states.
   // ------------------------------------------------------------------
   logic signed [11:0] ax, ay, bx, by, cx, cy;
   logic signed [12:0] dw, dh;
   logic [12:0]        adw, adh;
   logic signed [23:0] wsg, sxs, sys_w;
   logic signed [21:0] ly_w;
   logic               line_ok;
   logic [13:0]        lsum;
   logic signed [11:0] bxmin, bxmax, bymin, bymax;
   logic               box_bad;
   logic signed [19:0] p_alt;
   logic signed [20:0] d_val;
   logic [35:0]        thr_prod;
   logic [17:0]        trow_prod, rd_prod;
   logic signed [9:0]  px, py;
   logic signed [19:0] p_px_e2y, p_e2x_py, p_e1x_py, p_px_e1y;
   logic signed [20:0] wbn, wcn;
   logic signed [21:0] wa_c;
   logic               pass;
   logic [18:0]        mac_w;
   logic [23:0]        mac_op;
   logic [44:0]        mac_p;
   logic [20:0]        dtrial;
   logic               dge;
   logic [23:0]        qn;
   logic               dlast;

   assign ax = vert_x(va_ff);
   assign ay = vert_y(va_ff);
   assign bx = vert_x(vb_ff);
   assign by = vert_y(vb_ff);
   assign cx = vert_x(vc_ff);
   assign cy = vert_y(vc_ff);

   // Line setup: deltas, step directions and the first linear index.
   assign dw    = 13'(bx) - 13'(ax);
   assign dh    = 13'(by) - 13'(ay);
   assign adw   = dw[12] ? 13'(-dw) : 13'(dw);
   assign adh   = dh[12] ? 13'(-dh) : 13'(dh);
   assign wsg   = $signed({15'd0, width_ff});
   assign sxs   = (dw > 0) ? 24'sd1 : ((dw < 0) ? -24'sd1 : 24'sd0);
   assign sys_w = (dh > 0) ? wsg : ((dh < 0) ? -wsg : 24'sd0);
   assign ly_w  = ay * $signed({1'b0, width_ff});

   // Line step: the current index must lie inside the frame.
   assign line_ok = !lidx_ff[23] && (lidx_ff[22:0] < 23'(n_ff));
   assign lsum    = acc_ff + 14'(sht_ff);

   // Triangle bounding box.
   always_comb begin
      bxmin = ax;
      bxmax = ax;
      bymin = ay;
      bymax = ay;
      if (bx < bxmin) bxmin = bx;
      if (cx < bxmin) bxmin = cx;
      if (bx > bxmax) bxmax = bx;
      if (cx > bxmax) bxmax = cx;
      if (by < bymin) bymin = by;
      if (cy < bymin) bymin = cy;
      if (by > bymax) bymax = by;
      if (cy > bymax) bymax = cy;
   end

   assign box_bad = (bxmin < 0) || (bxmax >= $signed({3'd0, width_ff})) ||
                    (bymin < 0) || (bymax >= $signed({3'd0, height_ff}));

   // Triangle area and threshold scaling.
   assign p_alt     = e2x_ff * e1y_ff;
   assign d_val     = 21'(prod_ff) - 21'(p_alt);
   assign thr_prod  = thr_ff * dd_ff;
   assign trow_prod = ymin_ff * width_ff;
   assign rd_prod   = ry_ff * width_ff;

   // Edge functions of the current pixel, one product per state.
   assign px       = $signed({1'b0, x_ff}) - $signed({1'b0, tx0_ff});
   assign py       = $signed({1'b0, y_ff}) - $signed({1'b0, ty0_ff});
   assign p_px_e2y = px * e2y_ff;
   assign p_e2x_py = e2x_ff * py;
   assign p_e1x_py = e1x_ff * py;
   assign p_px_e1y = px * e1y_ff;

   // Weights normalized to a positive area.
   assign wbn  = neg_ff ? -wb_ff : wb_ff;
   assign wcn  = neg_ff ? -wc_ff : wc_ff;
   assign wa_c = $signed({2'b00, dd_ff}) - 22'(wbn) - 22'(wcn);

   assign pass = ($signed({wa_ff, 16'd0})  > $signed({2'b00, thrdd_ff})) &&
                 ($signed({wbp_ff, 16'd0}) > $signed({2'b00, thrdd_ff})) &&
                 ($signed({wcp_ff, 16'd0}) > $signed({2'b00, thrdd_ff}));

   // Multiply-accumulate operands: weight times vertex depth or channel.
   always_comb begin
      unique case (term_ff)
         2'd0:    mac_w = wa_ff[18:0];
         2'd1:    mac_w = wbp_ff[18:0];
         default: mac_w = wcp_ff[18:0];
      endcase
      mac_op = '0;
      unique case (sel_ff)
         SEL_DEPTH: begin
            unique case (term_ff)
               2'd0:    mac_op = vert_z(va_ff);
               2'd1:    mac_op = vert_z(vb_ff);
               default: mac_op = vert_z(vc_ff);
            endcase
         end
         SEL_CHAN0: begin
            unique case (term_ff)
               2'd0:    mac_op = {16'd0, ca_ff[7:0]};
               2'd1:    mac_op = {16'd0, cb_ff[7:0]};
               default: mac_op = {16'd0, cc_ff[7:0]};
            endcase
         end
         SEL_CHAN1: begin
            unique case (term_ff)
               2'd0:    mac_op = {16'd0, ca_ff[15:8]};
               2'd1:    mac_op = {16'd0, cb_ff[15:8]};
               default: mac_op = {16'd0, cc_ff[15:8]};
            endcase
         end
         default: begin
            unique case (term_ff)
               2'd0:    mac_op = {16'd0, ca_ff[23:16]};
               2'd1:    mac_op = {16'd0, cb_ff[23:16]};
               default: mac_op = {16'd0, cc_ff[23:16]};
            endcase
         end
      endcase
   end

   assign mac_p = mac_w * mac_op;

   // One restoring division step per cycle.
   assign dtrial = {rem_ff, low_ff[23]};
   assign dge    = (dtrial >= {1'b0, dd_ff});
   assign qn     = {q_ff[22:0], dge};
   assign dlast  = (sel_ff == SEL_DEPTH) ? (dcnt_ff == 5'(Z_BITS - 1))
                                         : (dcnt_ff == 5'(C_BITS - 1));

   // ------------------------------------------------------------------
   // Sequencer.
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_cmd)
                  CMD_FILL_COLOR: state_in = ST_FILL_C;
                  CMD_FILL_DEPTH: state_in = ST_FILL_D;
                  CMD_LINE:       state_in = ST_LINE_SET;
                  CMD_TRIANGLE:   state_in = ST_TRI_BOX;
                  CMD_READ:       state_in = ST_RD_ADDR;
                  default:        state_in = ST_DONE;
               endcase
            end
         end
         ST_FILL_C, ST_FILL_D: begin
            if (NW'(fcnt_ff) + NW'(1) == n_ff) state_in = ST_DONE;
         end
         ST_LINE_SET: state_in = ST_LINE_RUN;
         ST_LINE_RUN: begin
            if (!line_ok || lcnt_ff == lng_ff) state_in = ST_DONE;
         end
         ST_TRI_BOX:  state_in = box_bad ? ST_DONE : ST_TRI_D1;
         ST_TRI_D1:   state_in = ST_TRI_D2;
         ST_TRI_D2:   state_in = (d_val == 21'sd0) ? ST_DONE : ST_TRI_THR;
         ST_TRI_THR:  state_in = ST_TRI_IDX;
         ST_TRI_IDX:  state_in = ST_PIX_M1;
         ST_PIX_M1:   state_in = ST_PIX_M2;
         ST_PIX_M2:   state_in = ST_PIX_M3;
         ST_PIX_M3:   state_in = ST_PIX_M4;
         ST_PIX_M4:   state_in = ST_PIX_W;
         ST_PIX_W:    state_in = ST_PIX_THR;
         ST_PIX_THR:  state_in = pass ? ST_PIX_MAC : ST_PIX_ADV;
         ST_PIX_MAC: begin
            if (term_ff == 2'd2) state_in = ST_PIX_DIVI;
         end
         ST_PIX_DIVI: state_in = ST_PIX_DIV;
         ST_PIX_DIV: begin
            if (dlast) begin
               if (sel_ff == SEL_DEPTH) state_in = ST_PIX_ZCMP;
               else if (sel_ff == SEL_CHAN2) state_in = ST_PIX_CWR;
               else state_in = ST_PIX_MAC;
            end
         end
         ST_PIX_ZCMP: state_in = (q_ff > dep_rd_ff) ? ST_PIX_MAC : ST_PIX_ADV;
         ST_PIX_CWR:  state_in = ST_PIX_ADV;
         ST_PIX_ADV: begin
            if (x_ff == xmax_ff && y_ff == ymax_ff) state_in = ST_DONE;
            else state_in = ST_PIX_M1;
         end
         ST_RD_ADDR: state_in = ST_RD_MEM;
         ST_RD_MEM:  state_in = ST_RD_OUT;
         ST_RD_OUT:  state_in = ST_DONE;
         ST_DONE:    state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   // Datapath registers, loaded by the state that owns them.
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_ff       <= req_cmd;
               va_ff        <= req_vert_a;
               vb_ff        <= req_vert_b;
               vc_ff        <= req_vert_c;
               ca_ff        <= req_color_a;
               cb_ff        <= req_color_b;
               cc_ff        <= req_color_c;
               level_ff     <= req_line_level;
               dfill_ff     <= req_depth_fill;
               rx_ff        <= req_read_x;
               ry_ff        <= req_read_y;
               fcnt_ff      <= '0;
               out_color_ff <= '0;
               out_depth_ff <= '0;
            end
         end
         ST_FILL_C, ST_FILL_D: begin
            fcnt_ff <= fcnt_ff + ADDR_W'(1);
         end
         ST_LINE_SET: begin
            lidx_ff <= 24'(ly_w) + 24'(ax);
            linc0_ff <= sxs + sys_w;
            lcnt_ff <= '0;
            if (adw > adh) begin
               lng_ff   <= adw;
               sht_ff   <= adh;
               acc_ff   <= 14'(adw >> 1);
               linc1_ff <= sxs;
            end else begin
               lng_ff   <= adh;
               sht_ff   <= adw;
               acc_ff   <= 14'(adh >> 1);
               linc1_ff <= sys_w;
            end
         end
         ST_LINE_RUN: begin
            lcnt_ff <= lcnt_ff + 13'd1;
            if (lsum >= 14'(lng_ff)) begin
               acc_ff  <= lsum - 14'(lng_ff);
               lidx_ff <= lidx_ff + linc0_ff;
            end else begin
               acc_ff  <= lsum;
               lidx_ff <= lidx_ff + linc1_ff;
            end
         end
         ST_TRI_BOX: begin
            tx0_ff  <= ax[8:0];
            ty0_ff  <= ay[8:0];
            xmin_ff <= bxmin[8:0];
            xmax_ff <= bxmax[8:0];
            ymin_ff <= bymin[8:0];
            ymax_ff <= bymax[8:0];
            e1x_ff  <= $signed({1'b0, bx[8:0]}) - $signed({1'b0, ax[8:0]});
            e1y_ff  <= $signed({1'b0, by[8:0]}) - $signed({1'b0, ay[8:0]});
            e2x_ff  <= $signed({1'b0, cx[8:0]}) - $signed({1'b0, ax[8:0]});
            e2y_ff  <= $signed({1'b0, cy[8:0]}) - $signed({1'b0, ay[8:0]});
         end
         ST_TRI_D1: begin
            prod_ff <= e1x_ff * e2y_ff;
         end
         ST_TRI_D2: begin
            neg_ff <= d_val[20];
            dd_ff  <= d_val[20] ? 20'(-d_val) : 20'(d_val);
         end
         ST_TRI_THR: begin
            thrdd_ff <= thr_prod;
         end
         ST_TRI_IDX: begin
            x_ff    <= xmin_ff;
            y_ff    <= ymin_ff;
            tidx_ff <= ADDR_W'(trow_prod + 18'(xmin_ff));
            trow_ff <= ADDR_W'(trow_prod + 18'(xmin_ff));
         end
         ST_PIX_M1: begin
            prod_ff <= p_px_e2y;
         end
         ST_PIX_M2: begin
            wb_ff <= 21'(prod_ff) - 21'(p_e2x_py);
         end
         ST_PIX_M3: begin
            prod_ff <= p_e1x_py;
         end
         ST_PIX_M4: begin
            wc_ff <= 21'(prod_ff) - 21'(p_px_e1y);
         end
         ST_PIX_W: begin
            wa_ff  <= wa_c;
            wbp_ff <= 22'(wbn);
            wcp_ff <= 22'(wcn);
         end
         ST_PIX_THR: begin
            num_ff  <= '0;
            term_ff <= 2'd0;
            sel_ff  <= SEL_DEPTH;
         end
         ST_PIX_MAC: begin
            num_ff  <= num_ff + mac_p;
            term_ff <= term_ff + 2'd1;
         end
         ST_PIX_DIVI: begin
            dcnt_ff <= '0;
            q_ff    <= '0;
            if (sel_ff == SEL_DEPTH) begin
               rem_ff <= 20'(num_ff >> Z_BITS);
               low_ff <= num_ff[23:0];
            end else begin
               rem_ff <= 20'(num_ff >> C_BITS);
               low_ff <= {num_ff[7:0], 16'd0};
            end
         end
         ST_PIX_DIV: begin
            rem_ff  <= dge ? 20'(dtrial - {1'b0, dd_ff}) : dtrial[19:0];
            low_ff  <= {low_ff[22:0], 1'b0};
            q_ff    <= qn;
            dcnt_ff <= dcnt_ff + 5'd1;
            if (dlast) begin
               unique case (sel_ff)
                  SEL_CHAN0: col_ff[7:0]   <= qn[7:0];
                  SEL_CHAN1: col_ff[15:8]  <= qn[7:0];
                  SEL_CHAN2: col_ff[23:16] <= qn[7:0];
                  default: begin
                  end
               endcase
               if (sel_ff == SEL_CHAN0) sel_ff <= SEL_CHAN1;
               else if (sel_ff == SEL_CHAN1) sel_ff <= SEL_CHAN2;
               num_ff  <= '0;
               term_ff <= 2'd0;
            end
         end
         ST_PIX_ZCMP: begin
            sel_ff  <= SEL_CHAN0;
            num_ff  <= '0;
            term_ff <= 2'd0;
         end
         ST_PIX_ADV: begin
            if (x_ff == xmax_ff) begin
               x_ff    <= xmin_ff;
               y_ff    <= y_ff + 9'd1;
               trow_ff <= trow_ff + ADDR_W'(width_ff);
               tidx_ff <= trow_ff + ADDR_W'(width_ff);
            end else begin
               x_ff    <= x_ff + 9'd1;
               tidx_ff <= tidx_ff + ADDR_W'(1);
            end
         end
         ST_RD_ADDR: begin
            inb_ff  <= ({1'b0, rx_ff} < width_ff) && ({1'b0, ry_ff} < height_ff);
            tidx_ff <= ADDR_W'(rd_prod + 18'(rx_ff));
         end
         ST_RD_OUT: begin
            out_color_ff <= inb_ff ? col_rd_ff : 24'd0;
            out_depth_ff <= inb_ff ? dep_rd_ff : 24'd0;
         end
         default: begin
         end
      endcase
   end

   // Memory port control.
   always_comb begin
      col_we  = 1'b0;
      col_wa  = tidx_ff;
      col_wd  = col_ff;
      dep_we  = 1'b0;
      dep_wa  = tidx_ff;
      dep_wd  = q_ff;
      rd_en   = 1'b0;
      rd_addr = tidx_ff;
      unique case (state_ff)
         ST_FILL_C: begin
            col_we = 1'b1;
            col_wa = fcnt_ff;
            col_wd = ca_ff;
         end
         ST_FILL_D: begin
            dep_we = 1'b1;
            dep_wa = fcnt_ff;
            dep_wd = dfill_ff;
         end
         ST_LINE_RUN: begin
            col_we = line_ok;
            col_wa = lidx_ff[ADDR_W-1:0];
            col_wd = {level_ff, level_ff, level_ff};
         end
         ST_PIX_THR: begin
            rd_en = pass;
         end
         ST_PIX_ZCMP: begin
            dep_we = (q_ff > dep_rd_ff);
         end
         ST_PIX_CWR: begin
            col_we = 1'b1;
         end
         ST_RD_MEM: begin
            rd_en = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Colour store.
   always_ff @(posedge clock) begin
      if (col_we) color_mem[col_wa] <= col_wd;
      if (rd_en) col_rd_ff <= color_mem[rd_addr];
   end

   // Depth store.
   always_ff @(posedge clock) begin
      if (dep_we) depth_mem[dep_wa] <= dep_wd;
      if (rd_en) dep_rd_ff <= depth_mem[rd_addr];
   end

endmodule
